// ===== rtl/hps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Haptic pulse sequencer package
// Request codes, register indexes and the layout of one queued buzz entry.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int unsigned FIELD_W = 8;
    localparam int unsigned STRENGTH_W = 3;
    localparam int unsigned OFFSET_W = 3;
    localparam int unsigned REQ_W = 2;

    // Request kinds carried on the input tuser.
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PLAY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic REG_STRENGTH = 1'b0;
    localparam logic REG_OFFSET   = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] on_time;
        logic [FIELD_W-1:0] pause;
        logic [FIELD_W-1:0] repeats;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage : hps_pkg
`default_nettype wire

// ===== rtl/hps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Haptic pulse sequencer RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module hps_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 8
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : hps_ram
`default_nettype wire

// ===== rtl/haptic_pulse_sequencer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Haptic pulse sequencer
// Vibration motor sequencer with a ring queue of buzz entries in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries requests: tuser holds the request kind (tick,
//   play now, enqueue) and tdata holds length, pause and repeat count. Each
//   accepted transfer produces exactly one transfer on the master stream,
//   carrying the motor drive level after the request and a flag that is set
//   when an enqueue request was discarded because the queue was full.
//   Every request is handled in two steps: the first reads the queue entry
//   at the read pointer from the single-port-read RAM, the second updates the
//   counters, writes the entry back if needed and loads the output register.
//   A new request is only accepted once the previous one is updated, as set by
//   the RAM read latency in the read-modify-write of the queue.
//   A new request is accepted while an earlier result still waits in the
//   output register; if the receiver stalls, the update of the following
//   request waits until that result is taken, and no result is lost.
//   Reset clears the counters, pointers, motor level and both registers;
//   the queue memory is not cleared, since only written entries are read.
//   Registers must be written over APB while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module haptic_pulse_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Request stream.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // length [7:0], pause [15:8], repeat_req [23:16]
    input  wire  [1:0]  i_s_tuser,   // req_type [1:0]
    // Result stream.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // motor_on [0], dropped [1], zero [7:2]
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned FW = hps_pkg::FIELD_W;
    localparam int unsigned SW = hps_pkg::STRENGTH_W;
    localparam int unsigned OW = hps_pkg::OFFSET_W;

    // Sequencer states: wait for a request, then execute it.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // On time = ((2 * offset + length) * 2) mod 256.
    function automatic logic [FW-1:0] scaled_on_time(input logic [FW-1:0] len,
                                                     input logic [OW-1:0] off);
        logic [FW-1:0] off_ext;
        logic [FW-1:0] sum;
        off_ext = {{(FW-OW){off[OW-1]}}, off};
        sum = len + {off_ext[FW-2:0], 1'b0};
        return {sum[FW-2:0], 1'b0};
    endfunction

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Configuration registers.
    logic [SW-1:0] r_strength;
    logic [OW-1:0] r_len_off;

    // Control state.
    logic              r_state, n_state;
    logic [FW-1:0]     r_on_left, n_on_left;
    logic [FW-1:0]     r_pause_left, n_pause_left;
    logic [SW-1:0]     r_pwm, n_pwm;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic              r_drive, n_drive;
    logic              r_out_valid, n_out_valid;
    logic              r_dropped, n_dropped;

    // Captured request.
    logic [hps_pkg::REQ_W-1:0] r_req_type;
    logic [FW-1:0]             r_len;
    logic [FW-1:0]             r_pause;
    logic [FW-1:0]             r_rep;

    // Queue memory port.
    logic                   ram_we;
    logic [PTR_W-1:0]       ram_waddr;
    hps_pkg::t_entry        ram_wdata;
    hps_pkg::t_entry        ram_rdata;

    logic s_accept;
    logic commit;
    logic cfg_write;

    assign pready     = 1'b1;
    assign cfg_write  = psel & penable & pwrite & pready;
    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid & o_s_tready;
    // The update of a request waits until the output register is free.
    assign commit     = (r_state == S_EXEC) & (~r_out_valid | i_m_tready);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_dropped, r_drive};

    // Register read back.
    always_comb begin
        unique case (paddr[2])
            hps_pkg::REG_STRENGTH: prdata = {{(32-SW){1'b0}}, r_strength};
            hps_pkg::REG_OFFSET:   prdata = {{(32-OW){1'b0}}, r_len_off};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= '0;
            r_len_off  <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == hps_pkg::REG_STRENGTH) begin
                r_strength <= pwdata[SW-1:0];
            end else begin
                r_len_off <= pwdata[OW-1:0];
            end
        end
    end

    // The entry at the read pointer is read every cycle; it is valid in the
    // execute cycle because writes only happen at commit.
    hps_ram #(
        .WIDTH(hps_pkg::ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_rd_ptr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_on_left    = r_on_left;
        n_pause_left = r_pause_left;
        n_pwm        = r_pwm;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_drive      = r_drive;
        n_out_valid  = r_out_valid & ~i_m_tready;
        n_dropped    = r_dropped;
        ram_we       = 1'b0;
        ram_waddr    = r_wr_ptr;
        ram_wdata    = '{on_time: scaled_on_time(r_len, r_len_off),
                         pause:   r_pause,
                         repeats: r_rep - 1'b1};

        if (s_accept) begin
            n_state = S_EXEC;
        end

        if (commit) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_dropped   = 1'b0;
            unique case (r_req_type)
                hps_pkg::REQ_TICK: begin
                    if (r_on_left != '0) begin
                        n_on_left = r_on_left - 1'b1;
                        if (r_pwm != '0) begin
                            n_drive = 1'b1;
                            n_pwm   = r_pwm - 1'b1;
                        end else begin
                            n_drive = 1'b0;
                            n_pwm   = r_strength;
                        end
                    end else begin
                        n_drive = 1'b0;
                        if (r_pause_left != '0) begin
                            n_pause_left = r_pause_left - 1'b1;
                        end else if (r_rd_ptr != r_wr_ptr) begin
                            n_on_left    = ram_rdata.on_time;
                            n_pause_left = ram_rdata.pause;
                            if (ram_rdata.repeats == '0) begin
                                n_rd_ptr = next_ptr(r_rd_ptr);
                            end else begin
                                // Play the entry again: count down in place.
                                ram_we    = 1'b1;
                                ram_waddr = r_rd_ptr;
                                ram_wdata = '{on_time: ram_rdata.on_time,
                                              pause:   ram_rdata.pause,
                                              repeats: ram_rdata.repeats - 1'b1};
                            end
                        end
                    end
                end
                hps_pkg::REQ_PLAY: begin
                    n_on_left    = scaled_on_time(r_len, r_len_off);
                    n_pause_left = r_pause;
                    n_wr_ptr     = r_rd_ptr;
                    // Flushed queue is never full, so the repeat always fits.
                    if (r_rep != '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_rd_ptr;
                        ram_wdata = '{on_time: scaled_on_time(r_len, r_len_off),
                                      pause:   r_pause,
                                      repeats: r_rep - FW'(2)};
                        n_wr_ptr  = next_ptr(r_rd_ptr);
                    end
                end
                hps_pkg::REQ_ENQ: begin
                    if (next_ptr(r_wr_ptr) == r_rd_ptr) begin
                        n_dropped = 1'b1;
                    end else begin
                        ram_we   = 1'b1;
                        n_wr_ptr = next_ptr(r_wr_ptr);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_on_left    <= '0;
            r_pause_left <= '0;
            r_pwm        <= '0;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_drive      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dropped    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_on_left    <= n_on_left;
            r_pause_left <= n_pause_left;
            r_pwm        <= n_pwm;
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_drive      <= n_drive;
            r_out_valid  <= n_out_valid;
            r_dropped    <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req_type <= i_s_tuser;
            r_len      <= i_s_tdata[7:0];
            r_pause    <= i_s_tdata[15:8];
            r_rep      <= i_s_tdata[23:16];
        end
    end

`ifndef ASSERT_OFF
    // An accepted request always moves on to the execute cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    // Only an enqueue request can be reported as dropped.
    a_drop_enq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && n_dropped) |-> (r_req_type == hps_pkg::REQ_ENQ))
        else $error("drop flagged for a request that is not an enqueue");

    // The motor is only driven while a buzz is still running.
    a_drive_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && n_drive && !r_drive) |-> (r_on_left != '0))
        else $error("motor switched on without an active buzz");

    // Pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_ptr <= PTR_W'(QUEUE_DEPTH - 1)) && (r_wr_ptr <= PTR_W'(QUEUE_DEPTH - 1)))
        else $error("queue pointer outside the ring");

    // A result is only produced by the execute cycle of a request.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC))
        else $error("result appeared without an executed request");
`endif

endmodule : haptic_pulse_sequencer_top
`default_nettype wire
